// ----- src/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the s-curve motor pwm profile block
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned AccelW = 16;
  localparam int unsigned RunW   = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned AdvW   = 8;
  localparam int unsigned TimeW  = 18;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW   = 3;

  localparam logic [AccelW-1:0] AccelReset = AccelW'(2000);
  localparam logic [RunW-1:0]   RunReset   = RunW'(4000);
  localparam logic [DutyW-1:0]  PeakReset  = DutyW'(255);

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_ACCEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RUN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PEAK  = 2'd2;

  // phase codes
  localparam logic [1:0] PH_RAMP_UP   = 2'd0;
  localparam logic [1:0] PH_CRUISE    = 2'd1;
  localparam logic [1:0] PH_RAMP_DOWN = 2'd2;
  localparam logic [1:0] PH_STOP      = 2'd3;

  // multiplier steps, in issue order
  localparam logic [CntW-1:0] MS_XX  = 3'd0;
  localparam logic [CntW-1:0] MS_PK  = 3'd1;
  localparam logic [CntW-1:0] MS_NUM = 3'd2;
  localparam logic [CntW-1:0] MS_AA  = 3'd3;
  localparam logic [CntW-1:0] MS_DEN = 3'd4;

  localparam logic [CntW-1:0] DivLast = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            accept;
    logic            mul_en;
    logic [CntW-1:0] mul_step;
    logic            div_en;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic ramp;
  } sts_t;

endpackage

// ----- src/scm_ctrl.sv -----
// ----------------------------------------------------------------------------
// scm_ctrl
// sequencer: accept, multiply and divide steps for ramp items, output hand-off
// ----------------------------------------------------------------------------
module scm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  scm_pkg::sts_t sts_i,
  output scm_pkg::cmd_t cmd_o
);

  scm_pkg::state_e               state_q, state_d;
  logic [scm_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.ramp ? scm_pkg::ST_MUL : scm_pkg::ST_DONE;
        end
      end
      scm_pkg::ST_MUL: begin
        if (cnt_q == scm_pkg::MS_DEN) begin
          state_d = scm_pkg::ST_DIV;
        end
      end
      scm_pkg::ST_DIV: begin
        if (cnt_q == scm_pkg::DivLast) begin
          state_d = scm_pkg::ST_DONE;
        end
      end
      scm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = scm_pkg::ST_IDLE;
        end
      end
      default: state_d = scm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == scm_pkg::ST_IDLE) && in_valid_i;
    cmd_o.mul_en   = (state_q == scm_pkg::ST_MUL);
    cmd_o.mul_step = cnt_q;
    cmd_o.div_en   = (state_q == scm_pkg::ST_DIV);
    cmd_o.out_load = (state_q == scm_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
    in_stall_o     = (state_q != scm_pkg::ST_IDLE);
    out_valid_o    = out_valid_q;
  end

  always_comb begin
    cnt_d = (state_d != state_q) ? '0 : cnt_q + 1'b1;
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scm_pkg::ST_MUL && cnt_q == scm_pkg::MS_DEN) |=> state_q == scm_pkg::ST_DIV)
    else $error("multiply sequence did not hand over to divide");
  a_flat_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !sts_i.ramp) |=> state_q == scm_pkg::ST_DONE)
    else $error("flat phase item went through the arithmetic");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && state_q == scm_pkg::ST_IDLE)
    else $error("output load did not raise valid");
`endif

endmodule

// ----- src/scm_dp.sv -----
// ----------------------------------------------------------------------------
// scm_dp
// datapath: config registers, profile timing, shared multiplier, divider
// ----------------------------------------------------------------------------
module scm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [scm_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [scm_pkg::AdvW-1:0]      advance_ms_i,
  input  scm_pkg::cmd_t                 cmd_i,
  output scm_pkg::sts_t                 sts_o,
  output logic [scm_pkg::DutyW-1:0]     drive_a_o,
  output logic [scm_pkg::DutyW-1:0]     drive_b_o,
  output logic [1:0]                    phase_o,
  output logic                          forward_o
);

  localparam int unsigned NumW = 58;
  localparam int unsigned DsrW = 55;

  logic [scm_pkg::AccelW-1:0] accel_q;
  logic [scm_pkg::RunW-1:0]   run_q;
  logic [scm_pkg::DutyW-1:0]  peak_q;
  logic [scm_pkg::TimeW-1:0]  elapsed_q;
  logic                       fwd_q;
  logic [1:0]                 phase_q;
  logic                       dir_q;
  logic [15:0]                x_q;
  logic [17:0]                k_q;
  logic [31:0]                xx_q;
  logic [25:0]                pk_q;
  logic [31:0]                aa_q;
  logic [NumW-1:0]            rem_q;
  logic [DsrW-1:0]            dsr_q;
  logic [scm_pkg::DutyW-1:0]  quot_q;
  logic [scm_pkg::DutyW-1:0]  drive_a_q, drive_b_q;
  logic [1:0]                 phase_out_q;
  logic                       fwd_out_q;

  logic [scm_pkg::TimeW-1:0]  t_d;
  logic [scm_pkg::TimeW-1:0]  cruise_end;
  logic [scm_pkg::TimeW-1:0]  total_end;
  logic [scm_pkg::TimeW-1:0]  down_x;
  logic [1:0]                 phase_d;
  logic [15:0]                x_d;
  logic [31:0]                mul_a, mul_b;
  logic [63:0]                prod;
  logic [NumW-1:0]            dsr_ext;
  logic                       fits;
  logic [scm_pkg::DutyW-1:0]  duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= scm_pkg::AccelReset;
      run_q   <= scm_pkg::RunReset;
      peak_q  <= scm_pkg::PeakReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == scm_pkg::CFG_ACCEL) begin
        accel_q <= cfg_data_i[scm_pkg::AccelW-1:0];
      end else if (cfg_index_i == scm_pkg::CFG_RUN) begin
        run_q <= cfg_data_i[scm_pkg::RunW-1:0];
      end else if (cfg_index_i == scm_pkg::CFG_PEAK) begin
        peak_q <= cfg_data_i[scm_pkg::DutyW-1:0];
      end
    end
  end

  // phase decision for the incoming tick
  always_comb begin
    t_d        = elapsed_q + scm_pkg::TimeW'(advance_ms_i);
    cruise_end = scm_pkg::TimeW'(accel_q) + scm_pkg::TimeW'(run_q);
    total_end  = cruise_end + scm_pkg::TimeW'(accel_q);
    down_x     = total_end - t_d;
    x_d        = '0;
    if (t_d < scm_pkg::TimeW'(accel_q)) begin
      phase_d = scm_pkg::PH_RAMP_UP;
      x_d     = t_d[15:0];
    end else if (t_d < cruise_end) begin
      phase_d = scm_pkg::PH_CRUISE;
    end else if (t_d < total_end) begin
      phase_d = scm_pkg::PH_RAMP_DOWN;
      x_d     = down_x[15:0];
    end else begin
      phase_d = scm_pkg::PH_STOP;
    end
    sts_o.ramp = (phase_d == scm_pkg::PH_RAMP_UP) || (phase_d == scm_pkg::PH_RAMP_DOWN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      fwd_q     <= 1'b1;
    end else if (cmd_i.accept) begin
      if (phase_d == scm_pkg::PH_STOP) begin
        elapsed_q <= '0;
        fwd_q     <= ~fwd_q;
      end else begin
        elapsed_q <= t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      phase_q <= phase_d;
      dir_q   <= fwd_q;
      x_q     <= x_d;
      // 3a - 2x never goes negative since x <= a
      k_q     <= 18'(accel_q) * 18'd3 - {1'b0, x_d, 1'b0};
    end
  end

  // one shared multiplier, one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_step)
      scm_pkg::MS_XX: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      scm_pkg::MS_PK: begin
        mul_a = 32'(peak_q);
        mul_b = 32'(k_q);
      end
      scm_pkg::MS_NUM: begin
        mul_a = xx_q;
        mul_b = 32'(pk_q);
      end
      scm_pkg::MS_AA: begin
        mul_a = 32'(accel_q);
        mul_b = 32'(accel_q);
      end
      scm_pkg::MS_DEN: begin
        mul_a = aa_q;
        mul_b = 32'(accel_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // restoring division, quotient fits 8 bits since the ramp never passes peak
  always_comb begin
    dsr_ext = NumW'(dsr_q);
    fits    = (rem_q >= dsr_ext);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_step)
        scm_pkg::MS_XX:  xx_q  <= prod[31:0];
        scm_pkg::MS_PK:  pk_q  <= prod[25:0];
        scm_pkg::MS_NUM: rem_q <= prod[NumW-1:0];
        scm_pkg::MS_AA:  aa_q  <= prod[31:0];
        scm_pkg::MS_DEN: dsr_q <= {prod[47:0], 7'b0};
        default: ;
      endcase
    end else if (cmd_i.div_en) begin
      if (fits) begin
        rem_q <= rem_q - dsr_ext;
      end
      quot_q <= {quot_q[scm_pkg::DutyW-2:0], fits};
      dsr_q  <= dsr_q >> 1;
    end
  end

  always_comb begin
    unique case (phase_q)
      scm_pkg::PH_RAMP_UP,
      scm_pkg::PH_RAMP_DOWN: duty = quot_q;
      scm_pkg::PH_CRUISE:    duty = peak_q;
      default:               duty = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      drive_a_q   <= dir_q ? duty : '0;
      drive_b_q   <= dir_q ? '0 : duty;
      phase_out_q <= phase_q;
      fwd_out_q   <= dir_q;
    end
  end

  assign drive_a_o = drive_a_q;
  assign drive_b_o = drive_b_q;
  assign phase_o   = phase_out_q;
  assign forward_o = fwd_out_q;

endmodule

// ----- src/s_curve_motor_pwm_profile.sv -----
// ----------------------------------------------------------------------------
// s_curve_motor_pwm_profile
// smoothstep s-curve pwm profile for one h-bridge, controller plus datapath
// ----------------------------------------------------------------------------
// sequence: cruise and stop items skip the arithmetic and go straight to the
//   output hand-off; ramp items take five passes through the shared
//   multiplier and eight divide steps; the next item is taken while a
//   finished result still waits in the output register
// reset: asynchronous active low; elapsed time 0, direction forward,
//   registers at accel 2000 ms, run 4000 ms, peak duty 255
module s_curve_motor_pwm_profile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [scm_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [scm_pkg::AdvW-1:0]      advance_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [scm_pkg::DutyW-1:0]     drive_a_o,
  output logic [scm_pkg::DutyW-1:0]     drive_b_o,
  output logic [1:0]                    phase_o,
  output logic                          forward_o
);

  scm_pkg::cmd_t cmd;
  scm_pkg::sts_t sts;

  scm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .advance_ms_i (advance_ms_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .drive_a_o    (drive_a_o),
    .drive_b_o    (drive_b_o),
    .phase_o      (phase_o),
    .forward_o    (forward_o)
  );

endmodule
